// File: rtl/lfu_pkg.sv
// Shared constants for the frequency-based key-value cache.
// No dependencies; used by the channel interfaces, the cache core and the testbench.
`timescale 1ns / 1ps
`default_nettype none
package lfu_pkg;
	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 16;
	localparam int COUNT_BITS_DEF = 16;

	// Fixed field widths of the transaction payloads and the capacity register.
	localparam int KEY_W   = 16;
	localparam int VALUE_W = 32;
	localparam int CAP_W   = 5;

	localparam logic [CAP_W-1:0]   CAP_RESET  = 5'd16;
	localparam logic [VALUE_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	// Operation codes.
	localparam logic KIND_GET = 1'b0;
	localparam logic KIND_PUT = 1'b1;
endpackage
`default_nettype wire

// File: rtl/lfu_if.sv
// Valid/ready channel interfaces for request and response transactions.
// Depends on lfu_pkg for the payload widths.
`timescale 1ns / 1ps
`default_nettype none
interface lfu_req_if;
	import lfu_pkg::*;
	logic               valid;
	logic               ready;
	logic               kind;
	logic [KEY_W-1:0]   key;
	logic [VALUE_W-1:0] write_value;
	modport source (output valid, kind, key, write_value, input ready);
	modport sink (input valid, kind, key, write_value, output ready);
endinterface

interface lfu_rsp_if;
	import lfu_pkg::*;
	logic               valid;
	logic               ready;
	logic               found;
	logic [VALUE_W-1:0] read_value;
	logic               evicted;
	logic [KEY_W-1:0]   evicted_key;
	modport source (output valid, found, read_value, evicted, evicted_key, input ready);
	modport sink (input valid, found, read_value, evicted, evicted_key, output ready);
endinterface
`default_nettype wire

// File: rtl/lfu_cache_table_core.sv
// Top level of the frequency-based key-value cache.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if and lfu_ram.
//
// One request transaction (get or put) is handled at a time and yields exactly
// one response transaction. Entries live in a single RAM read one entry per
// cycle: a lookup sweep finds the hit, the eviction victim (lowest use count,
// oldest among equals) and the first free slot, then a read-modify-write sweep
// rewrites counts and recency ranks, and the key and value that a put writes. A
// get miss or a put at capacity zero skips the second sweep. Before it returns
// to idle an operation waits while the previous response is still held. Valid
// bits are flip-flops cleared by reset, so no clearing pass is needed. The user
// must write the capacity register only while no request is outstanding; the
// block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module lfu_cache_table_core #(
	parameter int ENTRIES    = lfu_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lfu_pkg::KEY_BITS_DEF,
	parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [lfu_pkg::CAP_W-1:0] cfg_wdata,
	lfu_req_if.sink                        req,
	lfu_rsp_if.source                      rsp
);
	import lfu_pkg::*;

	localparam int IDX_W = ENTRIES > 1 ? $clog2(ENTRIES) : 1;
	localparam int OCC_W = $clog2(ENTRIES + 1);
	localparam int CMP_W = OCC_W > CAP_W ? OCC_W : CAP_W;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_SCAN   = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_UPD    = 3'd3;
	localparam logic [2:0] S_DONE   = 3'd4;

	typedef struct packed {
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_W-1:0]    value;
		logic [COUNT_BITS-1:0] count;
		logic [IDX_W-1:0]      rank;
	} entry_t;

	logic [2:0]         state_q;
	logic [IDX_W:0]     sweep_q;
	logic               rvld_s1;
	logic [IDX_W-1:0]   ridx_s1;
	logic [CAP_W-1:0]   cap_q;
	logic [OCC_W-1:0]   occ_q;
	logic [ENTRIES-1:0] valid_q;

	logic                op_kind_q;
	logic [KEY_BITS-1:0] op_key_q;
	logic [VALUE_W-1:0]  op_wv_q;

	logic                  hit_q;
	logic [IDX_W-1:0]      hit_idx_q;
	logic [VALUE_W-1:0]    hit_val_q;
	logic [IDX_W-1:0]      hit_rank_q;
	logic                  vic_q;
	logic [IDX_W-1:0]      vic_idx_q;
	logic [COUNT_BITS-1:0] vic_cnt_q;
	logic [IDX_W-1:0]      vic_rank_q;
	logic [KEY_BITS-1:0]   vic_key_q;
	logic                  free_q;
	logic [IDX_W-1:0]      free_idx_q;

	logic             touch_q;
	logic             ins_q;
	logic             evict_q;
	logic [IDX_W-1:0] tgt_q;

	logic               rsp_valid_q;
	logic               rsp_found_q;
	logic [VALUE_W-1:0] rsp_value_q;
	logic               rsp_evicted_q;
	logic [KEY_W-1:0]   rsp_ekey_q;

	entry_t           rd_entry;
	entry_t           wr_entry;
	logic [$bits(entry_t)-1:0] ram_rdata;
	logic             ram_we;
	logic             rd_valid;
	logic             sweep_end;
	logic             req_acc;
	logic [CMP_W-1:0] cap_x;
	logic [CMP_W-1:0] cap_eff;
	logic             cap_nz;
	logic             is_put;
	logic             d_touch;
	logic             d_evict;
	logic             d_ins;
	logic [IDX_W-1:0] d_tgt;
	logic [ENTRIES-1:0] valid_ins;

	assign rd_entry  = entry_t'(ram_rdata);
	assign rd_valid  = valid_q[ridx_s1];
	assign sweep_end = sweep_q == (IDX_W + 1)'(ENTRIES);
	assign req_acc   = req.valid && req.ready;
	assign req.ready = state_q == S_IDLE;
	assign ram_we    = rvld_s1 && state_q == S_UPD;

	lfu_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ridx_s1),
		.wdata(wr_entry),
		.raddr(sweep_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	// Effective capacity and the replacement decision after the lookup sweep.
	always_comb begin
		cap_x   = CMP_W'(cap_q);
		cap_eff = cap_x > CMP_W'(ENTRIES) ? CMP_W'(ENTRIES) : cap_x;
		cap_nz  = cap_q != '0;
		is_put  = op_kind_q == KIND_PUT;
		d_touch = hit_q && (!is_put || cap_nz);
		d_evict = is_put && !hit_q && cap_nz && vic_q && (CMP_W'(occ_q) >= cap_eff);
		d_ins   = is_put && !hit_q && cap_nz && (free_q || d_evict);
		if (d_touch) begin
			d_tgt = hit_idx_q;
		end else if (d_evict && (!free_q || vic_idx_q < free_idx_q)) begin
			d_tgt = vic_idx_q;
		end else begin
			d_tgt = free_idx_q;
		end
	end

	// Valid bits after an insertion, with the victim cleared first.
	always_comb begin
		valid_ins = valid_q;
		if (evict_q) begin
			valid_ins[vic_idx_q] = 1'b0;
		end
		valid_ins[tgt_q] = 1'b1;
	end

	// New contents of the entry read back during the update sweep.
	always_comb begin
		wr_entry = rd_entry;
		if (touch_q) begin
			if (ridx_s1 == tgt_q) begin
				wr_entry.rank = '0;
				if (rd_entry.count != '1) begin
					wr_entry.count = rd_entry.count + COUNT_BITS'(1);
				end
				if (op_kind_q == KIND_PUT) begin
					wr_entry.value = op_wv_q;
				end
			end else if (rd_valid && rd_entry.rank < hit_rank_q) begin
				wr_entry.rank = rd_entry.rank + IDX_W'(1);
			end
		end else if (ins_q) begin
			if (ridx_s1 == tgt_q) begin
				wr_entry.key   = op_key_q;
				wr_entry.value = op_wv_q;
				wr_entry.count = COUNT_BITS'(1);
				wr_entry.rank  = '0;
			end else if (rd_valid && !(evict_q && ridx_s1 == vic_idx_q)) begin
				if (!(evict_q && rd_entry.rank > vic_rank_q)) begin
					wr_entry.rank = rd_entry.rank + IDX_W'(1);
				end
			end
		end
	end

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// Sequencer, sweep counter, valid bits and occupancy.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sweep_q <= '0;
			rvld_s1 <= 1'b0;
			valid_q <= '0;
			occ_q   <= '0;
		end else begin
			rvld_s1 <= (state_q == S_SCAN || state_q == S_UPD) && !sweep_end;
			if (state_q == S_SCAN || state_q == S_UPD) begin
				sweep_q <= sweep_q + (IDX_W + 1)'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= S_SCAN;
						sweep_q <= '0;
					end
				end
				S_SCAN: begin
					if (sweep_end) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					sweep_q <= '0;
					state_q <= (d_touch || d_ins) ? S_UPD : S_DONE;
				end
				S_UPD: begin
					if (sweep_end) begin
						state_q <= S_DONE;
						if (ins_q) begin
							if (!evict_q) begin
								occ_q <= occ_q + OCC_W'(1);
							end
							valid_q <= valid_ins;
						end
					end
				end
				S_DONE: begin
					if (!rsp_valid_q || rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Read index pipeline register, captured request payload and captured decision.
	always_ff @(posedge clk) begin
		ridx_s1 <= sweep_q[IDX_W-1:0];
		if (req_acc) begin
			op_kind_q <= req.kind;
			op_key_q  <= KEY_BITS'(req.key);
			op_wv_q   <= req.write_value;
		end
		if (state_q == S_DECIDE) begin
			touch_q <= d_touch;
			ins_q   <= d_ins;
			evict_q <= d_evict;
			tgt_q   <= d_tgt;
		end
	end

	// Lookup sweep: hit, victim and first free slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q  <= 1'b0;
			vic_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (req_acc) begin
			hit_q  <= 1'b0;
			vic_q  <= 1'b0;
			free_q <= 1'b0;
		end else if (rvld_s1 && state_q == S_SCAN) begin
			if (rd_valid && rd_entry.key == op_key_q && !hit_q) begin
				hit_q <= 1'b1;
			end
			if (rd_valid && (!vic_q || rd_entry.count < vic_cnt_q ||
				(rd_entry.count == vic_cnt_q && rd_entry.rank > vic_rank_q))) begin
				vic_q <= 1'b1;
			end
			if (!rd_valid && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rvld_s1 && state_q == S_SCAN) begin
			if (rd_valid && rd_entry.key == op_key_q && !hit_q) begin
				hit_idx_q  <= ridx_s1;
				hit_val_q  <= rd_entry.value;
				hit_rank_q <= rd_entry.rank;
			end
			if (rd_valid && (!vic_q || rd_entry.count < vic_cnt_q ||
				(rd_entry.count == vic_cnt_q && rd_entry.rank > vic_rank_q))) begin
				vic_idx_q  <= ridx_s1;
				vic_cnt_q  <= rd_entry.count;
				vic_rank_q <= rd_entry.rank;
				vic_key_q  <= rd_entry.key;
			end
			if (!rd_valid && !free_q) begin
				free_idx_q <= ridx_s1;
			end
		end
	end

	// Response register; the next request may arrive while it waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_DONE && (!rsp_valid_q || rsp.ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && (!rsp_valid_q || rsp.ready)) begin
			rsp_found_q   <= hit_q;
			rsp_value_q   <= (hit_q && op_kind_q == KIND_GET) ? hit_val_q : MISS_VALUE;
			rsp_evicted_q <= ins_q && evict_q && touch_q == 1'b0 && state_q == S_DONE
				&& (hit_q == 1'b0);
			rsp_ekey_q    <= (ins_q && evict_q && !hit_q) ? KEY_W'(vic_key_q) : '0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.found       = rsp_found_q;
	assign rsp.read_value  = rsp_value_q;
	assign rsp.evicted     = rsp_evicted_q;
	assign rsp.evicted_key = rsp_ekey_q;

	// Occupancy always matches the number of valid entries.
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy differs from valid entry count");

	// Occupancy never exceeds the table size.
	a_occ_max: assert property (@(posedge clk) disable iff (!arst_n)
		int'(occ_q) <= ENTRIES)
		else $error("occupancy above table size");

	// An update sweep either refreshes a hit or inserts, never both.
	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_UPD |-> !(touch_q && ins_q))
		else $error("touch and insert in one update sweep");

	// Insertion without eviction always has a free slot to land in.
	a_ins_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_UPD && ins_q && !evict_q) |-> free_q)
		else $error("insert without free slot");
endmodule
`default_nettype wire

// File: rtl/lfu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lfu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                         wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// File: bench/lfu_cache_table_core_tb.sv
// Self-checking testbench for the frequency-based key-value cache core.
// Depends on lfu_pkg, lfu_req_if, lfu_rsp_if and the RTL of lfu_cache_table_core.
// A transaction-level model predicts every response; responses are compared in order.
`timescale 1ns / 1ps
module lfu_cache_table_core_tb;
	import lfu_pkg::*;

	localparam int SLOTS      = ENTRIES_DEF;
	localparam int COUNT_TOP  = (1 << COUNT_BITS_DEF) - 1;
	localparam int DRAIN_WAIT = 2 * ENTRIES_DEF + 10;
	localparam int CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic               found;
		logic [VALUE_W-1:0] read_value;
		logic               evicted;
		logic [KEY_W-1:0]   evicted_key;
	} lookup_result_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CAP_W-1:0] cfg_wdata;

	lfu_req_if req_ch ();
	lfu_rsp_if rsp_ch ();

	lfu_cache_table_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// Cache model state.
	bit                 mdl_valid [SLOTS];
	logic [KEY_W-1:0]   mdl_key [SLOTS];
	logic [VALUE_W-1:0] mdl_value [SLOTS];
	int                 mdl_count [SLOTS];
	int                 mdl_rank [SLOTS];
	int                 mdl_occupancy;
	int                 mdl_capacity;

	lookup_result_t pending_results [$];
	int  error_count;
	int  cycle_count;
	int  sent_count;
	int  checked_count;
	int  evict_count;
	int  hit_count;
	int  burst_left;
	bit  gaps_enabled;
	int  stall_mode;
	int  stall_phase;

	// Clock generation.
	initial clk = 1'b0;
	always #6 clk = ~clk;

	// Run limit.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycle_count);
			$display("CHECK FAILED");
			$finish;
		end
	end

	// Response side ready pattern, chosen per test phase.
	always @(posedge clk) begin
		stall_phase <= stall_phase + 1;
		case (stall_mode)
			0: rsp_ch.ready <= 1'b1;
			1: rsp_ch.ready <= ($urandom_range(0, 1) == 1);
			2: rsp_ch.ready <= ((stall_phase % 11) < 4);
			default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	task automatic report(input string what, input logic [VALUE_W-1:0] got,
			input logic [VALUE_W-1:0] want);
		$display("Mismatch on %s at cycle %0d: got %h, expected %h", what, cycle_count,
			got, want);
		error_count++;
	endtask

	// Compare each response transaction with the oldest prediction.
	always @(posedge clk) begin
		lookup_result_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$display("Unexpected response at cycle %0d", cycle_count);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				checked_count++;
				if (rsp_ch.found !== want.found)
					report("found", rsp_ch.found, want.found);
				if (rsp_ch.read_value !== want.read_value)
					report("read_value", rsp_ch.read_value, want.read_value);
				if (rsp_ch.evicted !== want.evicted)
					report("evicted", rsp_ch.evicted, want.evicted);
				if (rsp_ch.evicted_key !== want.evicted_key)
					report("evicted_key", rsp_ch.evicted_key, want.evicted_key);
			end
		end
	end

	// Make an entry the newest and count one more use, saturating.
	function automatic void promote_entry(input int idx);
		int j;
		for (j = 0; j < SLOTS; j++)
			if (mdl_valid[j] && mdl_rank[j] < mdl_rank[idx])
				mdl_rank[j]++;
		mdl_rank[idx] = 0;
		if (mdl_count[idx] < COUNT_TOP)
			mdl_count[idx]++;
	endfunction

	// Work out the response of one operation and update the model.
	function automatic lookup_result_t cache_lookup(input logic kind,
			input logic [KEY_W-1:0] k, input logic [VALUE_W-1:0] wv);
		lookup_result_t r;
		int hit;
		int victim;
		int slot;
		int eff_cap;
		int i;
		r = '{found: 1'b0, read_value: MISS_VALUE, evicted: 1'b0, evicted_key: '0};
		hit = -1;
		victim = -1;
		slot = -1;
		eff_cap = (mdl_capacity > SLOTS) ? SLOTS : mdl_capacity;
		for (i = 0; i < SLOTS; i++)
			if (hit < 0 && mdl_valid[i] && mdl_key[i] == k)
				hit = i;
		r.found = (hit >= 0);
		if (hit >= 0)
			hit_count++;
		if (kind == KIND_GET) begin
			if (hit >= 0) begin
				r.read_value = mdl_value[hit];
				promote_entry(hit);
			end
			return r;
		end
		if (eff_cap == 0)
			return r;
		if (hit >= 0) begin
			mdl_value[hit] = wv;
			promote_entry(hit);
			return r;
		end
		// Full: drop the least used entry, the oldest among equal counts.
		if (mdl_occupancy >= eff_cap) begin
			for (i = 0; i < SLOTS; i++)
				if (mdl_valid[i] && (victim < 0 || mdl_count[i] < mdl_count[victim] ||
						(mdl_count[i] == mdl_count[victim] &&
						mdl_rank[i] > mdl_rank[victim])))
					victim = i;
			if (victim >= 0) begin
				r.evicted = 1'b1;
				r.evicted_key = mdl_key[victim];
				evict_count++;
				for (i = 0; i < SLOTS; i++)
					if (mdl_valid[i] && mdl_rank[i] > mdl_rank[victim])
						mdl_rank[i]--;
				mdl_valid[victim] = 1'b0;
				if (mdl_occupancy > 0)
					mdl_occupancy--;
			end
		end
		// Insert into the first free slot as the newest entry.
		for (i = 0; i < SLOTS; i++)
			if (slot < 0 && !mdl_valid[i])
				slot = i;
		if (slot >= 0) begin
			for (i = 0; i < SLOTS; i++)
				if (mdl_valid[i])
					mdl_rank[i]++;
			mdl_valid[slot] = 1'b1;
			mdl_key[slot] = k;
			mdl_value[slot] = wv;
			mdl_count[slot] = 1;
			mdl_rank[slot] = 0;
			mdl_occupancy++;
		end
		return r;
	endfunction

	// Send one request transaction; valid stays high when the next one follows at once.
	task automatic send_op(input logic kind, input logic [KEY_W-1:0] k,
			input logic [VALUE_W-1:0] wv);
		int gap;
		gap = 0;
		if (gaps_enabled) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 20);
			end else begin
				burst_left--;
			end
		end
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= kind;
		req_ch.key <= k;
		req_ch.write_value <= wv;
		do @(posedge clk); while (!req_ch.ready);
		pending_results.push_back(cache_lookup(kind, k, wv));
		sent_count++;
	endtask

	// Stop sending and wait until every predicted response has come back.
	task automatic wait_drained();
		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	// Write the capacity register while the core is idle.
	task automatic set_capacity(input int cap);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_wdata <= cap[CAP_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		mdl_capacity = cap;
	endtask

	// Directed cases: empty lookups, field extremes, overwrite, eviction order,
	// disabled puts and a capacity lowered below the occupancy.
	task automatic test_directed();
		gaps_enabled = 1'b0;
		stall_mode = 0;
		send_op(KIND_GET, 16'h0000, 32'h0);
		send_op(KIND_PUT, 16'h0000, 32'h7FFF_FFFF);
		send_op(KIND_PUT, 16'hFFFF, 32'h8000_0000);
		send_op(KIND_GET, 16'hFFFF, 32'hFFFF_FFFF);
		send_op(KIND_GET, 16'h0000, 32'h0);
		send_op(KIND_PUT, 16'h0000, 32'hFFFF_FFFF);
		send_op(KIND_GET, 16'h0000, 32'h1234_5678);
		set_capacity(4);
		send_op(KIND_PUT, 16'h1111, 32'h0000_0001);
		send_op(KIND_PUT, 16'h2222, 32'h0000_0002);
		send_op(KIND_GET, 16'h1111, 32'h0);
		send_op(KIND_GET, 16'h2222, 32'h0);
		// Equal counts: the older one goes first.
		send_op(KIND_PUT, 16'h3333, 32'h0000_0003);
		send_op(KIND_PUT, 16'h4444, 32'h0000_0004);
		send_op(KIND_GET, 16'h3333, 32'h0);
		send_op(KIND_PUT, 16'h5555, 32'h5555_AAAA);
		set_capacity(0);
		send_op(KIND_PUT, 16'h1111, 32'hDEAD_BEEF);
		send_op(KIND_PUT, 16'h6666, 32'hDEAD_BEEF);
		send_op(KIND_GET, 16'h1111, 32'h0);
		set_capacity(2);
		send_op(KIND_PUT, 16'h7777, 32'h0000_0007);
		send_op(KIND_PUT, 16'h8888, 32'h0000_0008);
		send_op(KIND_GET, 16'h7777, 32'h0);
		set_capacity(31);
		send_op(KIND_PUT, 16'h9999, 32'h0000_0009);
	endtask

	// Random operations over a small key set so that hits and evictions are common.
	task automatic random_phase(input int cap, input int ops, input int pool_size,
			input int mode, input bit gaps);
		logic [KEY_W-1:0] pool [$];
		logic [KEY_W-1:0] k;
		int n;
		set_capacity(cap);
		stall_mode = mode;
		gaps_enabled = gaps;
		pool.delete();
		pool.push_back(16'h0000);
		pool.push_back(16'hFFFF);
		while (pool.size() < pool_size)
			pool.push_back(KEY_W'($urandom));
		for (n = 0; n < ops; n++) begin
			if ($urandom_range(0, 19) == 0)
				k = KEY_W'($urandom);
			else
				k = pool[$urandom_range(0, pool.size() - 1)];
			send_op(($urandom_range(0, 2) != 0) ? KIND_PUT : KIND_GET, k, $urandom);
			// Hold off once, halfway through, until all responses are back.
			if (n == ops / 2)
				wait_drained();
		end
	endtask

	task automatic test_random();
		random_phase(16, 250, 24, 1, 1'b1);
		random_phase(1, 150, 4, 2, 1'b1);
		random_phase(5, 200, 10, 3, 1'b1);
		random_phase(31, 250, 20, 1, 1'b1);
		random_phase(0, 80, 12, 1, 1'b1);
		random_phase(9, 200, 14, 2, 1'b1);
		random_phase(3, 150, 6, 1, 1'b1);
	endtask

	// Back-to-back requests with the receiver always ready.
	task automatic test_no_idling();
		random_phase(16, 350, 20, 0, 1'b0);
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_GET;
		req_ch.key = '0;
		req_ch.write_value = '0;
		rsp_ch.ready = 1'b0;
		stall_mode = 0;
		stall_phase = 0;
		burst_left = 0;
		gaps_enabled = 1'b0;
		error_count = 0;
		cycle_count = 0;
		sent_count = 0;
		checked_count = 0;
		evict_count = 0;
		hit_count = 0;
		mdl_occupancy = 0;
		mdl_capacity = CAP_RESET;
		for (int i = 0; i < SLOTS; i++) begin
			mdl_valid[i] = 1'b0;
			mdl_key[i] = '0;
			mdl_value[i] = '0;
			mdl_count[i] = 0;
			mdl_rank[i] = 0;
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random();
		test_no_idling();
		wait_drained();

		$display("Ran %0d gets and puts (%0d hits, %0d evictions), %0d responses checked,",
			sent_count, hit_count, evict_count, checked_count);
		$display("across capacities 0 to 31 with random gaps and response stalls.");
		if (error_count == 0) begin
			$display("CHECK OK");
		end else begin
			$display("%0d mismatches", error_count);
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// File: sim.f
rtl/lfu_pkg.sv
rtl/lfu_if.sv
rtl/lfu_ram.sv
rtl/lfu_cache_table_core.sv
bench/lfu_cache_table_core_tb.sv
